FILE: rtl/ecpr_pkg.sv
// Package with the transaction types and sizing constants of the clock replacement core.
`timescale 1ns / 1ps

package ecpr_pkg;

    localparam int PAGE_W      = 4;
    localparam int FRAME_IDX_W = 2;
    localparam int FAULT_W     = 16;

    localparam int DEFAULT_PAGES  = 16;
    localparam int DEFAULT_FRAMES = 4;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic              is_write;
    } access_t;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [PAGE_W-1:0]      evicted_page;
        logic [FAULT_W-1:0]     fault_total;
    } result_t;

endpackage

FILE: rtl/enhanced_clock_page_replacement_core.sv
// Enhanced second-chance clock page replacement core over a frame table memory.
// A hit is reported once the lookup, reading frames in order from frame 0, reaches it;
// a fault runs the lookup over all FRAMES frames, then a sweep from the clock hand and
// then a result, with one frame table read per cycle.
// Throughput: busy drops while the result strobe is high, so the next start can be taken
// at the edge that accepts the result. Reset clears occupancy, clock hand and fault count.
`timescale 1ns / 1ps

module enhanced_clock_page_replacement_core #(
    parameter int PAGES  = ecpr_pkg::DEFAULT_PAGES,
    parameter int FRAMES = ecpr_pkg::DEFAULT_FRAMES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ecpr_pkg::access_t req,
    output logic              done,
    output ecpr_pkg::result_t rsp
);
    import ecpr_pkg::*;

    localparam int FW = $clog2(FRAMES);
    localparam int SW = (PAGES >= (1 << PAGE_W)) ? PAGE_W : $clog2(PAGES);
    localparam int EW = SW + 2;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_SWEEP  = 2'd2;

    localparam logic [FW-1:0]      LAST_FRAME = FW'(FRAMES - 1);
    localparam logic [FAULT_W-1:0] FAULT_MAX  = {FAULT_W{1'b1}};

    // Reduces a page number modulo PAGES by repeated compare and subtract.
    function automatic logic [PAGE_W-1:0] page_mod(input logic [PAGE_W-1:0] p);
        logic [PAGE_W-1:0] r;
        r = p;
        for (int i = 0; i < (1 << PAGE_W) / 2; i++) begin
            if (32'(r) >= PAGES) begin
                r = r - PAGE_W'(PAGES);
            end
        end
        return r;
    endfunction

    function automatic logic [FW-1:0] advance(input logic [FW-1:0] h);
        return (h == LAST_FRAME) ? '0 : h + 1'b1;
    endfunction

    // Frame table entry: {page, referenced, modified}.
    logic [EW-1:0] mem [FRAMES];
    logic [EW-1:0] rd_data_reg;
    logic [FW-1:0] rd_addr;
    logic          mem_we;
    logic [FW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;

    logic [1:0]         state_reg, state_next;
    logic [FRAMES-1:0]  occ_reg, occ_next;
    logic [FW-1:0]      hand_reg, hand_next;
    logic [FW-1:0]      pos_reg, pos_next;
    logic [FAULT_W-1:0] fault_reg, fault_next;
    logic [SW-1:0]      page_reg, page_next;
    logic               wr_reg, wr_next;
    logic               done_reg, done_next;
    result_t            rsp_reg, rsp_next;

    logic [SW-1:0] rd_page;
    logic          rd_ref;
    logic          rd_mod;

    assign rd_page = rd_data_reg[EW-1:2];
    assign rd_ref  = rd_data_reg[1];
    assign rd_mod  = rd_data_reg[0];

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        occ_next   = occ_reg;
        hand_next  = hand_reg;
        pos_next   = pos_reg;
        fault_next = fault_reg;
        page_next  = page_reg;
        wr_next    = wr_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        rd_addr    = '0;
        mem_we     = 1'b0;
        mem_waddr  = pos_reg;
        mem_wdata  = {page_reg, 1'b1, wr_reg};

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    page_next  = SW'(page_mod(req.page_number));
                    wr_next    = req.is_write;
                    pos_next   = '0;
                    rd_addr    = '0;
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH: begin
                if (occ_reg[pos_reg] && (rd_page == page_reg)) begin
                    mem_we                 = 1'b1;
                    mem_wdata              = {rd_page, 1'b1, rd_mod | wr_reg};
                    done_next              = 1'b1;
                    rsp_next.hit           = 1'b1;
                    rsp_next.frame_index   = FRAME_IDX_W'(pos_reg);
                    rsp_next.evicted_valid = 1'b0;
                    rsp_next.evicted_page  = '0;
                    rsp_next.fault_total   = fault_reg;
                    state_next             = ST_IDLE;
                end else if (pos_reg == LAST_FRAME) begin
                    // Miss: count the fault and start the sweep at the hand.
                    if (fault_reg != FAULT_MAX) begin
                        fault_next = fault_reg + 1'b1;
                    end
                    rd_addr    = hand_reg;
                    pos_next   = hand_reg;
                    state_next = ST_SWEEP;
                end else begin
                    rd_addr  = pos_reg + 1'b1;
                    pos_next = pos_reg + 1'b1;
                end
            end

            ST_SWEEP: begin
                if (!occ_reg[pos_reg] || (!rd_ref && !rd_mod)) begin
                    mem_we                 = 1'b1;
                    mem_wdata              = {page_reg, 1'b1, wr_reg};
                    occ_next[pos_reg]      = 1'b1;
                    hand_next              = advance(pos_reg);
                    done_next              = 1'b1;
                    rsp_next.hit           = 1'b0;
                    rsp_next.frame_index   = FRAME_IDX_W'(pos_reg);
                    rsp_next.evicted_valid = occ_reg[pos_reg];
                    rsp_next.evicted_page  = occ_reg[pos_reg] ? PAGE_W'(rd_page) : '0;
                    rsp_next.fault_total   = fault_reg;
                    state_next             = ST_IDLE;
                end else begin
                    // Second chance: clear referenced first, else clear modified.
                    mem_we    = 1'b1;
                    mem_wdata = rd_ref ? {rd_page, 1'b0, rd_mod} : {rd_page, 1'b0, 1'b0};
                    rd_addr   = advance(pos_reg);
                    pos_next  = advance(pos_reg);
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            hand_reg  <= '0;
            fault_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            hand_reg  <= hand_next;
            fault_reg <= fault_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        pos_reg  <= pos_next;
        page_reg <= page_next;
        wr_reg   <= wr_next;
        rsp_reg  <= rsp_next;
    end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the enhanced clock page replacement core.
`timescale 1ns / 1ps

module tb_top;

    import ecpr_pkg::*;

    localparam int PAGES  = DEFAULT_PAGES;
    localparam int FRAMES = DEFAULT_FRAMES;
    localparam logic [FAULT_W-1:0] FAULT_LIMIT = '1;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 2 * FRAMES + 8;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    access_t req   = '0;
    logic    busy;
    logic    done;
    result_t rsp;

    enhanced_clock_page_replacement_core #(
        .PAGES  (PAGES),
        .FRAMES (FRAMES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Shadow copy of the frame table, reference/modify bits, hand and fault counter.
    logic [PAGE_W-1:0]  shadow_page [FRAMES];
    bit                 shadow_occupied [FRAMES];
    bit                 shadow_referenced [FRAMES];
    bit                 shadow_modified [FRAMES];
    int                 shadow_hand = 0;
    logic [FAULT_W-1:0] shadow_faults = '0;

    access_t pending_accesses[$];
    result_t expected_results[$];
    int      sender_idle_pct = 8;
    int      mismatch_count = 0;
    int      results_checked = 0;
    int      hits_seen = 0;
    int      evictions_seen = 0;
    int      stall_cycles = 0;

    function automatic result_t predict_access(access_t acc);
        result_t r;
        bit      found;
        bit      chosen;
        int      h;
        r = '0;
        found = 1'b0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (!found && shadow_occupied[i] && shadow_page[i] == acc.page_number)
            begin
                found = 1'b1;
                r.frame_index = FRAME_IDX_W'(i);
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            shadow_referenced[r.frame_index] = 1'b1;
            if (acc.is_write)
                shadow_modified[r.frame_index] = 1'b1;
        end
        else
        begin
            if (shadow_faults != FAULT_LIMIT)
                shadow_faults++;
            h = shadow_hand;
            chosen = 1'b0;
            // Each frame needs at most two clearing passes before a victim appears.
            for (int n = 0; n < 2 * FRAMES + 1 && !chosen; n++)
            begin
                if (!shadow_occupied[h])
                    chosen = 1'b1;
                else if (!shadow_referenced[h] && !shadow_modified[h])
                begin
                    r.evicted_valid = 1'b1;
                    r.evicted_page  = shadow_page[h];
                    chosen = 1'b1;
                end
                else if (!shadow_referenced[h])
                begin
                    shadow_modified[h] = 1'b0;
                    h = (h + 1) % FRAMES;
                end
                else
                begin
                    shadow_referenced[h] = 1'b0;
                    h = (h + 1) % FRAMES;
                end
            end
            r.frame_index = FRAME_IDX_W'(h);
            shadow_page[h]       = acc.page_number;
            shadow_occupied[h]   = 1'b1;
            shadow_referenced[h] = 1'b1;
            shadow_modified[h]   = acc.is_write;
            shadow_hand = (h + 1) % FRAMES;
        end
        r.fault_total = shadow_faults;
        return r;
    endfunction

    task automatic queue_access(int page, bit wr);
        access_t acc;
        acc.page_number = PAGE_W'(page);
        acc.is_write    = wr;
        pending_accesses.push_back(acc);
    endtask

    // Most accesses fall in a small working set so that hits and sweeps both occur often.
    task automatic queue_random_accesses(int count);
        int base;
        base = $urandom_range(PAGES - 1);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(31) == 0)
                base = $urandom_range(PAGES - 1);
            if ($urandom_range(99) < 65)
                queue_access((base + $urandom_range(FRAMES)) % PAGES, 1'($urandom_range(1)));
            else
                queue_access($urandom_range(PAGES - 1), 1'($urandom_range(1)));
        end
    endtask

    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_accesses.size() != 0 || start || expected_results.size() != 0);
    endtask

    task automatic check_field(string field, logic [FAULT_W-1:0] want, logic [FAULT_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Driver: a request is held until it is taken by an edge with busy low.
    always @(posedge clk)
    begin : driver
        bit holding;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            holding = start;
            if (start && !busy)
            begin
                expected_results.push_back(predict_access(req));
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (pending_accesses.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    req   <= pending_accesses.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe must match the oldest outstanding transaction.
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with no transaction outstanding, actual %p", $time, rsp);
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.hit)
                    hits_seen++;
                if (want.evicted_valid)
                    evictions_seen++;
                check_field("hit", FAULT_W'(want.hit), FAULT_W'(rsp.hit));
                check_field("frame_index", FAULT_W'(want.frame_index),
                            FAULT_W'(rsp.frame_index));
                check_field("evicted_valid", FAULT_W'(want.evicted_valid),
                            FAULT_W'(rsp.evicted_valid));
                check_field("evicted_page", FAULT_W'(want.evicted_page),
                            FAULT_W'(rsp.evicted_page));
                check_field("fault_total", want.fault_total, rsp.fault_total);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Fill empty frames, hit with reads and writes, then force sweeps that
        // clear referenced bits, clear modified bits and evict clean frames.
        queue_access(0, 1'b0);
        queue_access(15, 1'b1);
        queue_access(0, 1'b0);
        queue_access(0, 1'b1);
        queue_access(15, 1'b0);
        queue_access(7, 1'b0);
        queue_access(8, 1'b1);
        queue_access(3, 1'b0);
        queue_access(9, 1'b1);
        queue_access(10, 1'b0);
        queue_access(3, 1'b1);
        queue_access(11, 1'b0);
        queue_access(12, 1'b1);
        queue_access(1, 1'b0);
        queue_access(2, 1'b0);
        queue_access(4, 1'b1);
        queue_access(2, 1'b1);
        queue_access(5, 1'b0);
        queue_access(15, 1'b1);
        queue_access(0, 1'b1);
        queue_access(6, 1'b0);

        sender_idle_pct = 8;
        queue_random_accesses(270);
        wait_for_drain();

        sender_idle_pct = 70;
        queue_random_accesses(270);
        wait_for_drain();

        sender_idle_pct = 0;
        queue_random_accesses(260);
        wait_for_drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d transactions: %0d hits, %0d evictions.",
                 results_checked, hits_seen, evictions_seen);
        $display("Fault counter reached %0d under idle rates of 8, 70 and 0 percent.",
                 shadow_faults);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ecpr_pkg.sv
rtl/enhanced_clock_page_replacement_core.sv
tb/tb_top.sv
